// File: src/necd_pkg.sv
// ----------------------------------------------------------------------------
// necd_pkg
// Shared types and constants of the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necd_pkg;

    localparam int unsigned STAMP_W    = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FRAME_BITS = 32;
    localparam int unsigned BITS_W     = 6;
    localparam int unsigned ELAPSED_W  = 8;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [ELAPSED_W-1:0] WINDOW_MS   = 8'd140;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 8'd255;

    // op field codes
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // kind field codes
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_REPEAT  = 1'b1;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LEADER_MIN = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LEADER_MAX = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_MIN = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_MAX = 4'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MIN   = 4'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ZERO_MAX   = 4'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_MIN    = 4'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_ONE_MAX    = 4'd7;

    typedef struct packed {
        logic [STAMP_W-1:0] lo;
        logic [STAMP_W-1:0] hi;
    } t_window;

    typedef struct packed {
        t_window leader;
        t_window rpt;
        t_window zero;
        t_window one;
    } t_cfg;

    typedef enum logic [4:0] {
        IV_NONE   = 5'b00001,
        IV_LEADER = 5'b00010,
        IV_REPEAT = 5'b00100,
        IV_ZERO   = 5'b01000,
        IV_ONE    = 5'b10000
    } t_iv_class;

endpackage

// File: src/necd_if.sv
// ----------------------------------------------------------------------------
// necd_in_if / necd_out_if
// Valid/ready channels carrying capture words and decoded result words.
// ----------------------------------------------------------------------------
interface necd_in_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [necd_pkg::STAMP_W-1:0]  stamp;

    modport source (output valid, output op, output stamp, input ready);
    modport sink   (input valid, input op, input stamp, output ready);
endinterface

interface necd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [necd_pkg::BYTE_W-1:0]   address;
    logic [necd_pkg::BYTE_W-1:0]   command;

    modport source (output valid, output kind, output address, output command, input ready);
    modport sink   (input valid, input kind, input address, input command, output ready);
endinterface

// File: src/necd_cfg.sv
// ----------------------------------------------------------------------------
// necd_cfg
// Interval window registers, written through a plain write port.
// ----------------------------------------------------------------------------
module necd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [necd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [necd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output necd_pkg::t_cfg                  o_cfg
);

    necd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leader.lo <= 16'd13000;
            r_cfg.leader.hi <= 16'd14000;
            r_cfg.rpt.lo    <= 16'd10750;
            r_cfg.rpt.hi    <= 16'd11750;
            r_cfg.zero.lo   <= 16'd800;
            r_cfg.zero.hi   <= 16'd1400;
            r_cfg.one.lo    <= 16'd1700;
            r_cfg.one.hi    <= 16'd2600;
        end else if (i_cfg_we) begin
            // indexes beyond the last register are dropped
            case (i_cfg_addr)
                necd_pkg::REG_LEADER_MIN: r_cfg.leader.lo <= i_cfg_wdata;
                necd_pkg::REG_LEADER_MAX: r_cfg.leader.hi <= i_cfg_wdata;
                necd_pkg::REG_REPEAT_MIN: r_cfg.rpt.lo    <= i_cfg_wdata;
                necd_pkg::REG_REPEAT_MAX: r_cfg.rpt.hi    <= i_cfg_wdata;
                necd_pkg::REG_ZERO_MIN:   r_cfg.zero.lo   <= i_cfg_wdata;
                necd_pkg::REG_ZERO_MAX:   r_cfg.zero.hi   <= i_cfg_wdata;
                necd_pkg::REG_ONE_MIN:    r_cfg.one.lo    <= i_cfg_wdata;
                necd_pkg::REG_ONE_MAX:    r_cfg.one.hi    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: src/necd_classify.sv
// ----------------------------------------------------------------------------
// necd_classify
// Wrapped interval between captures, classed against the timing windows.
// ----------------------------------------------------------------------------
module necd_classify (
    input  logic [necd_pkg::STAMP_W-1:0] i_stamp,
    input  logic [necd_pkg::STAMP_W-1:0] i_prev_stamp,
    input  necd_pkg::t_cfg               i_cfg,
    output necd_pkg::t_iv_class          o_class
);

    logic [necd_pkg::STAMP_W-1:0] interval;
    logic                         hit_leader;
    logic                         hit_repeat;
    logic                         hit_zero;
    logic                         hit_one;

    assign interval   = i_stamp - i_prev_stamp;
    assign hit_leader = (interval >= i_cfg.leader.lo) && (interval <= i_cfg.leader.hi);
    assign hit_repeat = (interval >= i_cfg.rpt.lo)    && (interval <= i_cfg.rpt.hi);
    assign hit_zero   = (interval >= i_cfg.zero.lo)   && (interval <= i_cfg.zero.hi);
    assign hit_one    = (interval >= i_cfg.one.lo)    && (interval <= i_cfg.one.hi);

    // leader wins over repeat, repeat over zero, zero over one
    always_comb begin
        if (hit_leader) begin
            o_class = necd_pkg::IV_LEADER;
        end else if (hit_repeat) begin
            o_class = necd_pkg::IV_REPEAT;
        end else if (hit_zero) begin
            o_class = necd_pkg::IV_ZERO;
        end else if (hit_one) begin
            o_class = necd_pkg::IV_ONE;
        end else begin
            o_class = necd_pkg::IV_NONE;
        end
    end

endmodule

// File: src/nec_ir_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_core
// NEC infrared frame decoder: captures and ticks in, commands and repeats out.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one word per falling-edge capture (op = edge, stamp = the
//   microsecond counter) or per millisecond tick (op = tick). o_out carries
//   a word for every verified frame (kind = command) and for every repeat
//   code seen within 140 ms of the last accepted frame or repeat. The user
//   writes the window registers on the i_cfg_* port while idle (unenforced).
// Timing:
//   An accepted word is held in an input register; the classify, shift and
//   check logic runs on it and loads the output register, which drives
//   o_out.valid, once the output register is free or draining. One word
//   is taken every clock while o_out is not stalled, set by the single
//   input register feeding the output register.
// Reset and stall:
//   Synchronous reset restores the default windows and clears the decoder
//   state. While o_out is stalled with a word pending, the input register
//   holds and i_in.ready drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [necd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [necd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    necd_in_if.sink                         i_in,
    necd_out_if.source                      o_out
);

    necd_pkg::t_cfg      cfg;
    necd_pkg::t_iv_class iv_class;

    // input register
    logic                          r_in_valid, n_in_valid;
    logic                          r_in_op;
    logic [necd_pkg::STAMP_W-1:0]  r_in_stamp;

    // decoder state
    logic [necd_pkg::STAMP_W-1:0]   r_prev_stamp, n_prev_stamp;
    logic                           r_prev_valid, n_prev_valid;
    logic                           r_receiving, n_receiving;
    logic [necd_pkg::FRAME_BITS-1:0] r_shift, n_shift;
    logic [necd_pkg::BITS_W-1:0]    r_bits, n_bits;
    logic [necd_pkg::ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [necd_pkg::BYTE_W-1:0]    r_held_addr, n_held_addr;
    logic [necd_pkg::BYTE_W-1:0]    r_held_cmd, n_held_cmd;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_kind, n_out_kind;
    logic [necd_pkg::BYTE_W-1:0]  r_out_addr, n_out_addr;
    logic [necd_pkg::BYTE_W-1:0]  r_out_cmd, n_out_cmd;

    logic                           advance;
    logic                           take;
    logic                           emit;
    logic                           emit_kind;
    logic [necd_pkg::FRAME_BITS-1:0] shifted;
    logic [necd_pkg::BITS_W-1:0]    bits_inc;
    logic [necd_pkg::BYTE_W-1:0]    f_addr, f_addr_n, f_cmd, f_cmd_n;

    necd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    necd_classify u_classify (
        .i_stamp      (r_in_stamp),
        .i_prev_stamp (r_prev_stamp),
        .i_cfg        (cfg),
        .o_class      (iv_class)
    );

    // the held word is processed once the output slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign take       = i_in.valid && i_in.ready;

    assign shifted  = {r_shift[necd_pkg::FRAME_BITS-2:0], (iv_class == necd_pkg::IV_ONE)};
    assign bits_inc = r_bits + 1'b1;
    assign f_addr   = shifted[31:24];
    assign f_addr_n = shifted[23:16];
    assign f_cmd    = shifted[15:8];
    assign f_cmd_n  = shifted[7:0];

    always_comb begin
        n_in_valid   = take || (r_in_valid && !advance);
        n_prev_stamp = r_prev_stamp;
        n_prev_valid = r_prev_valid;
        n_receiving  = r_receiving;
        n_shift      = r_shift;
        n_bits       = r_bits;
        n_elapsed    = r_elapsed;
        n_held_addr  = r_held_addr;
        n_held_cmd   = r_held_cmd;
        emit         = 1'b0;
        emit_kind    = necd_pkg::KIND_COMMAND;

        if (advance) begin
            if (r_in_op == necd_pkg::OP_TICK) begin
                if (r_elapsed != necd_pkg::ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end else if (!r_prev_valid) begin
                // first capture only sets the reference
                n_prev_stamp = r_in_stamp;
                n_prev_valid = 1'b1;
            end else begin
                n_prev_stamp = r_in_stamp;
                case (iv_class)
                    necd_pkg::IV_LEADER: begin
                        n_receiving = 1'b1;
                        n_shift     = '0;
                        n_bits      = '0;
                    end
                    necd_pkg::IV_REPEAT: begin
                        n_receiving = 1'b0;
                        n_shift     = '0;
                        n_bits      = '0;
                        if (r_elapsed <= necd_pkg::WINDOW_MS) begin
                            n_elapsed = '0;
                            emit      = 1'b1;
                            emit_kind = necd_pkg::KIND_REPEAT;
                        end
                    end
                    necd_pkg::IV_ZERO, necd_pkg::IV_ONE: begin
                        if (r_receiving) begin
                            if (bits_inc == necd_pkg::BITS_W'(necd_pkg::FRAME_BITS)) begin
                                n_receiving = 1'b0;
                                n_shift     = '0;
                                n_bits      = '0;
                                if ((f_addr == ~f_addr_n) && (f_cmd == ~f_cmd_n)) begin
                                    n_held_addr = f_addr;
                                    n_held_cmd  = f_cmd;
                                    n_elapsed   = '0;
                                    emit        = 1'b1;
                                end
                            end else begin
                                n_shift = shifted;
                                n_bits  = bits_inc;
                            end
                        end
                    end
                    default: begin
                        // bad interval aborts a frame in progress
                        n_receiving = 1'b0;
                        n_shift     = '0;
                        n_bits      = '0;
                    end
                endcase
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = emit_kind;
            n_out_addr  = n_held_addr;
            n_out_cmd   = n_held_cmd;
        end else begin
            n_out_valid = r_out_valid && !o_out.ready;
            n_out_kind  = r_out_kind;
            n_out_addr  = r_out_addr;
            n_out_cmd   = r_out_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_prev_stamp <= '0;
            r_prev_valid <= 1'b0;
            r_receiving  <= 1'b0;
            r_shift      <= '0;
            r_bits       <= '0;
            r_elapsed    <= '0;
            r_held_addr  <= '0;
            r_held_cmd   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_prev_stamp <= n_prev_stamp;
            r_prev_valid <= n_prev_valid;
            r_receiving  <= n_receiving;
            r_shift      <= n_shift;
            r_bits       <= n_bits;
            r_elapsed    <= n_elapsed;
            r_held_addr  <= n_held_addr;
            r_held_cmd   <= n_held_cmd;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_op    <= i_in.op;
            r_in_stamp <= i_in.stamp;
        end
        r_out_kind <= n_out_kind;
        r_out_addr <= n_out_addr;
        r_out_cmd  <= n_out_cmd;
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.address = r_out_addr;
    assign o_out.command = r_out_cmd;

endmodule
